/* rtl/core/mt_pkg.sv */
// Shared types, constants and word functions of the MT19937 generator.
`timescale 1ns / 1ps
package mt_pkg;

    localparam int WORD_W       = 32;
    localparam int STATE_WORDS  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int COUNT_W      = $clog2(STATE_WORDS);

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic {
        CMD_DRAW = 1'b0,
        CMD_SEED = 1'b1
    } cmd_t;

    localparam word_t  MATRIX_A   = 32'h9908_B0DF;
    localparam word_t  UPPER_MASK = 32'h8000_0000;
    localparam word_t  LOWER_MASK = 32'h7FFF_FFFF;
    localparam word_t  SEED_MULT  = 32'd1812433253;
    localparam word_t  TEMPER_B   = 32'h9D2C_5680;
    localparam word_t  TEMPER_C   = 32'hEFC6_0000;
    localparam count_t LAST_WORD  = COUNT_W'(STATE_WORDS - 1);

    typedef struct packed {
        logic busy;
    } seed_stat_t;

    function automatic word_t mix_word(input word_t hi, input word_t lo, input word_t far);
        word_t y;
        word_t r;
        y = (hi & UPPER_MASK) | (lo & LOWER_MASK);
        r = far ^ (y >> 1);
        if (lo[0])
        begin
            r = r ^ MATRIX_A;
        end
        return r;
    endfunction

    function automatic word_t temper(input word_t w);
        word_t e;
        e = w;
        e = e ^ (e >> 11);
        e = e ^ ((e << 7) & TEMPER_B);
        e = e ^ ((e << 15) & TEMPER_C);
        e = e ^ (e >> 18);
        return e;
    endfunction

endpackage

/* rtl/core/mt_cell.sv */
// One word cell of the state chain, loading from its neighbour on a shift.
`timescale 1ns / 1ps
module mt_cell (
    input  logic          clk,
    input  logic          shift,
    input  mt_pkg::word_t din,
    output mt_pkg::word_t dout
);
    import mt_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        word_next = shift ? din : word_reg;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign dout = word_reg;

endmodule

/* rtl/core/mt_seeder.sv */
// Seed sequencer: produces the initial state words, one per cycle.
`timescale 1ns / 1ps
module mt_seeder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mt_pkg::word_t      seed,
    output mt_pkg::seed_stat_t stat,
    output mt_pkg::word_t      word
);
    import mt_pkg::*;

    logic   busy_reg;
    logic   busy_next;
    count_t cnt_reg;
    count_t cnt_next;
    word_t  s_reg;
    word_t  s_next;
    word_t  folded;
    word_t  product;

    always_comb
    begin
        folded  = s_reg ^ (s_reg >> 30);
        product = SEED_MULT * folded;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        s_next    = s_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            s_next    = seed;
        end
        else if (busy_reg)
        begin
            s_next   = product + WORD_W'(cnt_reg) + 32'd1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_WORD)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

    assign stat.busy = busy_reg;
    assign word      = s_reg;

endmodule

/* rtl/core/mt19937_random_generator.sv */
// Top level of the MT19937 generator: cell chain, twist, tempering and handshake.
//
// Usage:
//   Command channel (item_valid/item_ready) carries command and seed_value.
//   command 0 draws one word; command 1 reseeds and gives no result.
//   Result channel (result_valid/result_ready) carries random_word.
//   A draw is answered in the cycle after acceptance; draws sustain one
//   item per cycle while the receiver takes each result, since each shift
//   of the 624-cell chain twists exactly one new word from cells 0, 1 and 397.
//   A seed rewrites all 624 cells after acceptance, one word per cycle from
//   the seed multiplier; item_ready stays low meanwhile.
//   After reset the store is not cleared, but draws return zero until the
//   first seed; no clearing pass is needed.
//   The result sits in an output register; while the receiver stalls with a
//   word pending, item_ready drops and nothing is lost or repeated.
`timescale 1ns / 1ps
module mt19937_random_generator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  logic          command,
    input  mt_pkg::word_t seed_value,
    output logic          result_valid,
    input  logic          result_ready,
    output mt_pkg::word_t random_word
);
    import mt_pkg::*;

    word_t      cell_word [STATE_WORDS];
    word_t      tail_word;
    word_t      twisted;
    word_t      seed_word;
    seed_stat_t seed_stat;
    logic       shift;
    logic       take;
    logic       draw;
    logic       seed_start;
    logic       blank_reg;
    logic       blank_next;
    logic       valid_reg;
    logic       valid_next;
    word_t      out_reg;
    word_t      out_next;

    assign item_ready = !seed_stat.busy && (!valid_reg || result_ready);
    assign take       = item_valid && item_ready;
    assign draw       = take && (command == CMD_DRAW);
    assign seed_start = take && (command == CMD_SEED);

    mt_seeder u_seeder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_start),
        .seed  (seed_value),
        .stat  (seed_stat),
        .word  (seed_word)
    );

    assign twisted   = mix_word(cell_word[0], cell_word[1], cell_word[SHIFT_OFFSET]);
    assign tail_word = seed_stat.busy ? seed_word : twisted;
    assign shift     = seed_stat.busy || (draw && !blank_reg);

    for (genvar i = 0; i < STATE_WORDS; i++)
    begin : g_cell
        if (i == STATE_WORDS - 1)
        begin : g_tail
            mt_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .din   (tail_word),
                .dout  (cell_word[i])
            );
        end
        else
        begin : g_body
            mt_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .din   (cell_word[i+1]),
                .dout  (cell_word[i])
            );
        end
    end

    always_comb
    begin
        blank_next = blank_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        if (seed_start)
        begin
            blank_next = 1'b0;
        end
        if (valid_reg && result_ready)
        begin
            valid_next = 1'b0;
        end
        if (draw)
        begin
            valid_next = 1'b1;
            out_next   = blank_reg ? '0 : temper(twisted);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            blank_reg <= blank_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = valid_reg;
    assign random_word  = out_reg;

endmodule
